// ----- rtl/far_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// far_pkg: shared types and constants for the fraction arithmetic reducer
// Holds the command and status codes, operand and result widths, state
// encoding, transaction structs and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int NUM_OUT_BITS = 34;
  localparam int DEN_OUT_BITS = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                     command;
    logic signed [OPERAND_BITS-1:0] num_a;
    logic [OPERAND_BITS-1:0]        den_a;
    logic signed [OPERAND_BITS-1:0] num_b;
    logic [OPERAND_BITS-1:0]        den_b;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_OUT_BITS-1:0] result_num;
    logic [DEN_OUT_BITS-1:0]        result_den;
    logic [1:0]                     status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD1,
    S_DIVD,
    S_DIVB,
    S_MUL,
    S_COMBINE,
    S_GCD2,
    S_DIVM,
    S_DIVN,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic gcd_init;
    logic gcd_step;
    logic mul;
    logic combine;
    logic div_init_d;
    logic div_init_b;
    logic div_init_m;
    logic div_init_n;
    logic div_step;
    logic save_dscale;
    logic save_bscale;
    logic save_mag;
    logic save_den;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_den;
    logic div_zero;
    logic is_addsub;
    logic gcd_done;
    logic div_done;
    logic mag_zero;
  } stat_t;

endpackage : far_pkg
`default_nettype wire

// ----- rtl/far_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// far_ctrl: sequencing state machine
// Steps the datapath through checks, gcd, scaling, combine and reduction.
// ----------------------------------------------------------------------------
module far_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  far_pkg::stat_t      stat,
  output far_pkg::ctrl_t      ctrl,
  output logic                busy,
  output logic                done
);
  import far_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.zero_den || stat.div_zero) state_next = S_DONE;
        else if (stat.is_addsub)            state_next = S_GCD1;
        else                                state_next = S_MUL;
      end
      S_GCD1:    if (stat.gcd_done) state_next = S_DIVD;
      S_DIVD:    if (stat.div_done) state_next = S_DIVB;
      S_DIVB:    if (stat.div_done) state_next = S_MUL;
      S_MUL:     state_next = S_COMBINE;
      S_COMBINE: state_next = S_GCD2;
      S_GCD2: begin
        if (stat.mag_zero)      state_next = S_DONE;
        else if (stat.gcd_done) state_next = S_DIVM;
      end
      S_DIVM:    if (stat.div_done) state_next = S_DIVN;
      S_DIVN:    if (stat.div_done) state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    unique case (state)
      S_IDLE:  ctrl.load = start;
      S_CHECK: ctrl.gcd_init = stat.is_addsub;
      S_GCD1: begin
        ctrl.gcd_step   = !stat.gcd_done;
        ctrl.div_init_d = stat.gcd_done;
      end
      S_DIVD: begin
        ctrl.div_step    = !stat.div_done;
        ctrl.save_dscale = stat.div_done;
        ctrl.div_init_b  = stat.div_done;
      end
      S_DIVB: begin
        ctrl.div_step    = !stat.div_done;
        ctrl.save_bscale = stat.div_done;
      end
      S_MUL:     ctrl.mul = 1'b1;
      S_COMBINE: ctrl.combine = 1'b1;
      S_GCD2: begin
        ctrl.gcd_step   = !stat.gcd_done && !stat.mag_zero;
        ctrl.div_init_m = stat.gcd_done && !stat.mag_zero;
      end
      S_DIVM: begin
        ctrl.div_step   = !stat.div_done;
        ctrl.save_mag   = stat.div_done;
        ctrl.div_init_n = stat.div_done;
      end
      S_DIVN: begin
        ctrl.div_step = !stat.div_done;
        ctrl.save_den = stat.div_done;
      end
      S_DONE:  ctrl = '0;
      default: ctrl = '0;
    endcase
  end

endmodule : far_ctrl
`default_nettype wire

// ----- rtl/far_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// far_dpath: fraction arithmetic datapath
// Sign/magnitude split, shared binary gcd unit (one step per cycle), shared
// restoring divider, combinational 16x16 products and the signed combine.
// ----------------------------------------------------------------------------
module far_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [1:0]                           command,
  input  wire logic [far_pkg::OPERAND_BITS-1:0]     num_a,
  input  wire logic [far_pkg::OPERAND_BITS-1:0]     den_a,
  input  wire logic [far_pkg::OPERAND_BITS-1:0]     num_b,
  input  wire logic [far_pkg::OPERAND_BITS-1:0]     den_b,
  input  far_pkg::ctrl_t                            ctrl,
  output far_pkg::stat_t                            stat,
  output logic [far_pkg::NUM_OUT_BITS-1:0]          result_num,
  output logic [far_pkg::DEN_OUT_BITS-1:0]          result_den,
  output logic [1:0]                                status
);
  import far_pkg::*;

  localparam int OB = OPERAND_BITS;
  localparam int WB = 2 * OB + 1;            // wide magnitude width
  localparam int CB = $clog2(WB + 1);

  // latched operands
  cmd_t          cmd;
  logic          sa, sc;
  logic [OB-1:0] ma, mb, mc, md;
  logic [OB-1:0] ma_in, mc_in;

  // gcd unit
  logic [WB-1:0] gx, gy, g_val;
  logic [CB-1:0] gk;

  // divider
  logic [WB-1:0] dq, dr, dv;
  logic [CB-1:0] dcnt;
  logic [WB+1:0] rem_try;
  logic          rem_neg;
  logic [WB-1:0] rem_sel;

  // products, combine and reduced result
  logic [OB-1:0]   dscale, bscale;       // d / gcd(b,d), b / gcd(b,d)
  logic [OB-1:0]   den_factor;
  logic [2*OB-1:0] prod_p, prod_q, prod_den;
  logic [WB-1:0]   p, q, den, mag, mag_next, mag_red, den_red;
  logic            addsub, sq, sres, sres_next;
  logic [NUM_OUT_BITS-1:0] num_wide;

  assign ma_in = num_a[OB-1] ? -num_a : num_a;
  assign mc_in = num_b[OB-1] ? -num_b : num_b;

  // operand latch
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd <= CMD_ADD;
      sa  <= 1'b0;
      sc  <= 1'b0;
      ma  <= '0;
      mb  <= '0;
      mc  <= '0;
      md  <= '0;
    end else if (ctrl.load) begin
      cmd <= cmd_t'(command);
      sa  <= num_a[OB-1];
      sc  <= num_b[OB-1];
      ma  <= ma_in;
      mc  <= mc_in;
      mb  <= den_a;
      md  <= den_b;
    end
  end

  // binary gcd: strip common twos into gk, then shift or subtract-and-halve
  always_ff @(posedge clk) begin
    if (rst) begin
      gx <= '0;
      gy <= '0;
      gk <= '0;
    end else if (ctrl.gcd_init) begin
      gx <= WB'(mb);
      gy <= WB'(md);
      gk <= '0;
    end else if (ctrl.combine) begin
      gx <= mag_next;
      gy <= den;
      gk <= '0;
    end else if (ctrl.gcd_step) begin
      priority if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 1'b1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
  end

  // gcd once one side reaches zero
  assign g_val = (gx | gy) << gk;

  // restoring divider step
  assign rem_try = {1'b0, dr, dq[WB-1]} - {2'b00, dv};
  assign rem_neg = rem_try[WB+1];
  assign rem_sel = rem_neg ? {dr[WB-2:0], dq[WB-1]} : rem_try[WB-1:0];

  // divider: narrow dividends sit in the top bits and take OB steps
  always_ff @(posedge clk) begin
    if (rst) begin
      dq   <= '0;
      dr   <= '0;
      dv   <= '0;
      dcnt <= '0;
    end else if (ctrl.div_init_d || ctrl.div_init_b || ctrl.div_init_m ||
                 ctrl.div_init_n) begin
      dr <= '0;
      dv <= g_val;
      priority if (ctrl.div_init_d) begin
        dq   <= {md, {(WB-OB){1'b0}}};
        dcnt <= CB'(OB);
      end else if (ctrl.div_init_b) begin
        dq   <= {mb, {(WB-OB){1'b0}}};
        dcnt <= CB'(OB);
      end else if (ctrl.div_init_m) begin
        dq   <= mag;
        dcnt <= CB'(WB);
      end else begin
        dq   <= den;
        dcnt <= CB'(WB);
      end
    end else if (ctrl.div_step && dcnt != '0) begin
      dr   <= rem_sel;
      dq   <= {dq[WB-2:0], ~rem_neg};
      dcnt <= dcnt - 1'b1;
    end
  end

  // quotient capture
  always_ff @(posedge clk) begin
    if (rst) begin
      dscale  <= '0;
      bscale  <= '0;
      mag_red <= '0;
      den_red <= '0;
    end else begin
      if (ctrl.save_dscale) dscale <= dq[OB-1:0];
      if (ctrl.save_bscale) bscale <= dq[OB-1:0];
      if (ctrl.save_mag)    mag_red <= dq;
      if (ctrl.save_den)    den_red <= dq;
    end
  end

  // product operands per command
  assign addsub = (cmd == CMD_ADD) || (cmd == CMD_SUB);

  always_comb begin
    if (addsub) begin
      prod_p     = (2*OB)'(ma) * (2*OB)'(dscale);
      prod_q     = (2*OB)'(mc) * (2*OB)'(bscale);
      den_factor = dscale;
    end else if (cmd == CMD_MUL) begin
      prod_p     = (2*OB)'(ma) * (2*OB)'(mc);
      prod_q     = '0;
      den_factor = md;
    end else begin
      prod_p     = (2*OB)'(ma) * (2*OB)'(md);
      prod_q     = '0;
      den_factor = mc;
    end
  end

  assign prod_den = (2*OB)'(mb) * (2*OB)'(den_factor);

  // signed combine of the two scaled numerators
  assign sq = (cmd == CMD_SUB) ? !sc : sc;

  always_comb begin
    if (addsub) begin
      if (sa == sq) begin
        mag_next  = p + q;
        sres_next = sa;
      end else if (p >= q) begin
        mag_next  = p - q;
        sres_next = sa;
      end else begin
        mag_next  = q - p;
        sres_next = sq;
      end
    end else begin
      mag_next  = p;
      sres_next = sa ^ sc;
    end
  end

  // product and combine registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p    <= '0;
      q    <= '0;
      den  <= '0;
      mag  <= '0;
      sres <= 1'b0;
    end else begin
      if (ctrl.mul) begin
        p   <= WB'(prod_p);
        q   <= WB'(prod_q);
        den <= WB'(prod_den);
      end
      if (ctrl.combine) begin
        mag  <= mag_next;
        sres <= sres_next;
      end
    end
  end

  // status to controller
  always_comb begin
    stat.zero_den  = (mb == '0) || (md == '0);
    stat.div_zero  = (cmd == CMD_DIV) && (mc == '0);
    stat.is_addsub = addsub;
    stat.gcd_done  = (gx == '0) || (gy == '0);
    stat.div_done  = (dcnt == '0);
    stat.mag_zero  = (mag == '0);
  end

  // result fields, valid while the controller is in its done state
  assign num_wide = NUM_OUT_BITS'(mag_red);

  always_comb begin
    priority if (stat.zero_den) begin
      result_num = '0;
      result_den = '0;
      status     = ST_ZERO_DEN;
    end else if (stat.div_zero) begin
      result_num = '0;
      result_den = '0;
      status     = ST_DIV_ZERO;
    end else if (stat.mag_zero) begin
      result_num = '0;
      result_den = DEN_OUT_BITS'(1);
      status     = ST_OK;
    end else begin
      result_num = sres ? -num_wide : num_wide;
      result_den = DEN_OUT_BITS'(den_red);
      status     = ST_OK;
    end
  end

endmodule : far_dpath
`default_nettype wire

// ----- rtl/fraction_arithmetic_reducer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_arithmetic_reducer_unit: exact fraction add/sub/mul/div
// Pulse start while busy is low; one result appears with done for one cycle.
// ----------------------------------------------------------------------------
// One transaction at a time. A rejected transaction (zero denominator or
// division by zero) goes from the check straight to done. For multiply and
// divide the time grows with the number of binary gcd steps on the result
// (at most 65); a zero result ends early, after the combine. Add and
// subtract first also run the gcd steps on the denominators (at most 32)
// and the two scale divides. The time is set by the shared gcd unit and the
// restoring divider (16 steps for each scale factor, 33 for each reduction
// divide). busy drops in the cycle after done, when the next start can be
// taken. The result is valid from the done cycle until the next start is
// taken, and the receiver cannot stall it.
module fraction_arithmetic_reducer_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  far_pkg::in_item_t        in_item,
  output logic                     busy,
  output logic                     done,
  output far_pkg::out_item_t       out_item
);
  import far_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // controller
  far_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy),
    .done (done)
  );

  // datapath
  far_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .command   (in_item.command),
    .num_a     (in_item.num_a),
    .den_a     (in_item.den_a),
    .num_b     (in_item.num_b),
    .den_b     (in_item.den_b),
    .ctrl      (ctrl),
    .stat      (stat),
    .result_num(out_item.result_num),
    .result_den(out_item.result_den),
    .status    (out_item.status)
  );

endmodule : fraction_arithmetic_reducer_unit
`default_nettype wire
